@@ sv/lie_pkg.sv @@
package lie_pkg;

	// sizes and number formats
	localparam int MAX_POINTS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int INNER_FRAC = 2 * FRAC_BITS;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam logic signed [63:0] INNER_ONE = 64'sd1 <<< INNER_FRAC;
	localparam logic signed [63:0] INNER_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] INNER_MIN = 64'sh8000_0000_0000_0000;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_EVAL  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_OK  = 2'd0,
		ERR_DUP = 2'd1,
		ERR_SAT = 2'd2
	} err_t;

	// datapath operations issued by the sequencer
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLEAR,
		OP_BUILD_INIT,
		OP_EVAL_INIT,
		OP_LATCH_XI,
		OP_DUPCMP,
		OP_MUL,
		OP_POLY_UPD,
		OP_POLY_WR0,
		OP_T_SET,
		OP_DER_WR,
		OP_DIV,
		OP_W_SET,
		OP_QUO_TOP,
		OP_QUO_UPD,
		OP_COEF_UPD,
		OP_SUM_UPD,
		OP_PW_UPD,
		OP_EMIT_COEF,
		OP_EMIT_ERR,
		OP_EMIT_EVAL
	} op_t;

	// multiplier operand pairs
	typedef enum logic [2:0] {
		MS_NEGXI_POLY,
		MS_T_DIFF,
		MS_XI_QUO,
		MS_QUO_W,
		MS_COEF_PW,
		MS_PW_XI
	} msel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_DUP_XI,
		ST_DUP_CMP,
		ST_POLY_XI,
		ST_POLY_MUL,
		ST_POLY_WAIT,
		ST_DER_XI,
		ST_DER_MUL,
		ST_DER_WAIT,
		ST_QUO_XI,
		ST_QUO_DWAIT,
		ST_QUO_TOP,
		ST_QUO_MUL,
		ST_QUO_WAIT,
		ST_COEF_MUL,
		ST_COEF_WAIT,
		ST_EMIT,
		ST_EMIT_ERR,
		ST_EV_CHK,
		ST_EV_WAIT1,
		ST_EV_MUL2,
		ST_EV_WAIT2,
		ST_EV_EMIT
	} state_t;

	typedef struct packed {
		op_t              op;
		msel_t            msel;
		logic [CNT_W-1:0] idx;
		logic             last;
		logic             in_ready;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [CNT_W-1:0] n;
		logic [CNT_W-1:0] cv;
		logic             dup;
		logic             mul_done;
		logic             div_done;
		logic             out_free;
		logic             in_valid;
	} dp_stat_t;

	typedef struct packed {
		logic signed [63:0] val;
		logic               sat;
	} sat_res_t;

	// point format to inner format, exact
	function automatic logic signed [63:0] to_inner(input logic [31:0] raw);
		return {{(32 - FRAC_BITS){raw[31]}}, raw, {FRAC_BITS{1'b0}}};
	endfunction

	// magnitude of a signed value, full 64-bit range
	function automatic logic [63:0] mag64(input logic signed [63:0] a);
		return a[63] ? 64'(-a) : 64'(a);
	endfunction

	// clamp a wide magnitude and apply the sign
	function automatic sat_res_t apply_sign(input logic [63:0] hi, input logic [63:0] lo,
			input logic neg);
		logic [63:0] limit;
		logic [63:0] m;
		sat_res_t    r;
		limit = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		r.sat = (hi != 64'd0) || (lo > limit);
		m     = r.sat ? limit : lo;
		r.val = neg ? $signed(64'(-m)) : $signed(m);
		return r;
	endfunction

	// saturating add
	function automatic sat_res_t sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		sat_res_t           r;
		s     = a + b;
		r.sat = (a[63] == b[63]) && (s[63] != a[63]);
		r.val = r.sat ? (a[63] ? INNER_MIN : INNER_MAX) : s;
		return r;
	endfunction

endpackage

@@ sv/lie_req_if.sv @@
interface lie_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic signed [31:0] x_value;
	logic signed [31:0] y_value;

	modport source(output valid, output command, output x_value, output y_value, input ready);
	modport sink(input valid, input command, input x_value, input y_value, output ready);
endinterface

@@ sv/lie_rsp_if.sv @@
interface lie_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] result_value;
	logic [3:0]         coef_index;
	logic               is_coefficient;
	logic               last;
	logic [1:0]         error;

	modport source(output valid, output result_value, output coef_index,
		output is_coefficient, output last, output error, input ready);
	modport sink(input valid, input result_value, input coef_index,
		input is_coefficient, input last, input error, output ready);
endinterface

@@ sv/lie_mul.sv @@
module lie_mul import lie_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic               busy,
	output logic               done,
	output logic signed [63:0] res,
	output logic               sat
);

	logic         busy_q, done_q, neg_q, sat_q;
	logic [2:0]   step_q;
	logic [63:0]  ma_q, mb_q;
	logic [127:0] acc_q;
	logic signed [63:0] res_q;
	logic [31:0]  a_part, b_part;
	logic [63:0]  pp;
	logic [127:0] pp_sh, v;
	sat_res_t     fin;

	// one 32x32 partial product per step
	always_comb begin
		a_part = step_q[0] ? ma_q[63:32] : ma_q[31:0];
		b_part = step_q[1] ? mb_q[63:32] : mb_q[31:0];
		pp     = a_part * b_part;
		case (step_q[1:0])
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
		v   = acc_q >> INNER_FRAC;
		fin = apply_sign(v[127:64], v[63:0], neg_q);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 3'd0;
		end else begin
			done_q <= !start && busy_q && (step_q == 3'd5);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (busy_q) begin
				if (step_q == 3'd5) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	// accumulate, round, clamp
	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= mag64(a);
			mb_q  <= mag64(b);
			neg_q <= a[63] ^ b[63];
			acc_q <= 128'd0;
		end else if (busy_q) begin
			if (step_q < 3'd4) begin
				acc_q <= acc_q + pp_sh;
			end else if (step_q == 3'd4) begin
				acc_q <= acc_q + (128'd1 << (INNER_FRAC - 1));
			end else begin
				res_q <= fin.val;
				sat_q <= fin.sat;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign res  = res_q;
	assign sat  = sat_q;

endmodule

@@ sv/lie_div.sv @@
module lie_div import lie_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic               done,
	output logic signed [63:0] res,
	output logic               sat
);

	localparam logic [7:0] STEPS = 8'd128;

	logic         busy_q, done_q, neg_q, sat_q;
	logic [7:0]   cnt_q;
	logic [127:0] num_q, q_q;
	logic [63:0]  rem_q, d_q, ma, mb;
	logic signed [63:0] res_q;
	logic [64:0]  trial;
	logic         ge, rnd;
	logic [63:0]  rem_nx;
	sat_res_t     fin;

	// one quotient bit per cycle
	always_comb begin
		ma     = mag64(a);
		mb     = mag64(b);
		trial  = {rem_q, num_q[127]};
		ge     = trial >= {1'b0, d_q};
		rem_nx = ge ? 64'(trial - {1'b0, d_q}) : trial[63:0];
		rnd    = rem_q >= (d_q - rem_q);
		fin    = apply_sign(q_q[127:64], q_q[63:0], neg_q);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 8'd0;
		end else begin
			done_q <= start ? (mb == 64'd0) : (busy_q && (cnt_q == STEPS + 8'd1));
			if (start) begin
				busy_q <= (mb != 64'd0);
				cnt_q  <= 8'd0;
			end else if (busy_q) begin
				if (cnt_q == STEPS + 8'd1) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 8'd1;
				end
			end
		end
	end

	// shift-subtract, round half up, clamp
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {64'd0, ma} << INNER_FRAC;
			q_q   <= 128'd0;
			rem_q <= 64'd0;
			d_q   <= mb;
			neg_q <= a[63] ^ b[63];
			if (mb == 64'd0) begin
				res_q <= (ma == 64'd0) ? 64'sd0 : (a[63] ? INNER_MIN : INNER_MAX);
				sat_q <= (ma != 64'd0);
			end
		end else if (busy_q) begin
			if (cnt_q < STEPS) begin
				num_q <= {num_q[126:0], 1'b0};
				q_q   <= {q_q[126:0], ge};
				rem_q <= rem_nx;
			end else if (cnt_q == STEPS) begin
				q_q <= q_q + {127'd0, rnd};
			end else begin
				res_q <= fin.val;
				sat_q <= fin.sat;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign sat  = sat_q;

endmodule

@@ sv/lie_dp.sv @@
module lie_dp import lie_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic               req_valid,
	input  logic [1:0]         req_command,
	input  logic [31:0]        req_x,
	input  logic [31:0]        req_y,
	input  logic               rsp_ready,
	output logic               rsp_valid,
	output logic signed [63:0] rsp_result_value,
	output logic [3:0]         rsp_coef_index,
	output logic               rsp_is_coefficient,
	output logic               rsp_last,
	output logic [1:0]         rsp_error
);

	// node and polynomial stores
	logic [31:0]        xs_q   [MAX_POINTS];
	logic [31:0]        ys_q   [MAX_POINTS];
	logic signed [63:0] poly_q [MAX_POINTS+1];
	logic signed [63:0] der_q  [MAX_POINTS];
	logic signed [63:0] coef_q [MAX_POINTS];
	logic signed [63:0] quo_q  [MAX_POINTS];

	logic [CNT_W-1:0]   cnt_q, cv_q;
	logic               sat_q, dup_q, ov_q;
	cmd_t               cmd_in_q;
	logic [31:0]        inx_q, iny_q;
	logic signed [63:0] xi_q, t_q, w_q, sum_q, pw_q;
	logic signed [63:0] o_val_q;
	logic [3:0]         o_idx_q;
	logic               o_coef_q, o_last_q;
	err_t               o_err_q;

	logic [IDX_W-1:0]   ix;
	logic [CNT_W-1:0]   poly_ra;
	logic [31:0]        x_rd, y_rd;
	logic signed [63:0] poly_rd, der_rd, coef_rd, quo_rd;
	logic signed [63:0] ma, mb, add_a;
	logic               mul_start, mul_busy, mul_done, mul_sat;
	logic signed [63:0] mul_res;
	logic               div_start, div_done, div_sat;
	logic signed [63:0] div_res;
	logic               is_add, out_free, emit, accept;
	sat_res_t           add_r;

	assign accept   = req_valid && cmd.in_ready;
	assign out_free = !ov_q || rsp_ready;
	assign emit     = (cmd.op == OP_EMIT_COEF) || (cmd.op == OP_EMIT_ERR) ||
		(cmd.op == OP_EMIT_EVAL);

	// store read ports, one address each
	always_comb begin
		ix = cmd.idx[IDX_W-1:0];
		case (cmd.op)
			OP_POLY_UPD: poly_ra = cmd.idx - CNT_W'(1);
			OP_QUO_TOP:  poly_ra = cmd.idx + CNT_W'(1);
			default:     poly_ra = cmd.idx;
		endcase
		x_rd    = xs_q[ix];
		y_rd    = ys_q[ix];
		der_rd  = der_q[ix];
		coef_rd = coef_q[ix];
		quo_rd  = quo_q[ix];
		poly_rd = poly_q[poly_ra];
	end

	// multiplier operands
	always_comb begin
		case (cmd.msel)
			MS_NEGXI_POLY: begin ma = -xi_q;   mb = poly_rd; end
			MS_T_DIFF:     begin ma = t_q;     mb = xi_q - to_inner(x_rd); end
			MS_XI_QUO:     begin ma = xi_q;    mb = quo_rd; end
			MS_QUO_W:      begin ma = quo_rd;  mb = w_q; end
			MS_COEF_PW:    begin ma = coef_rd; mb = pw_q; end
			default:       begin ma = pw_q;    mb = xi_q; end
		endcase
	end

	assign mul_start = (cmd.op == OP_MUL);
	assign div_start = (cmd.op == OP_DIV);

	// shared saturating adder, second operand is the product
	always_comb begin
		is_add = 1'b1;
		case (cmd.op)
			OP_POLY_UPD, OP_QUO_UPD: add_a = poly_rd;
			OP_COEF_UPD:             add_a = coef_rd;
			OP_SUM_UPD:              add_a = sum_q;
			default: begin
				add_a  = poly_rd;
				is_add = 1'b0;
			end
		endcase
		add_r = sat_add(add_a, mul_res);
	end

	lie_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (ma),
		.b      (mb),
		.busy   (mul_busy),
		.done   (mul_done),
		.res    (mul_res),
		.sat    (mul_sat)
	);

	lie_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (to_inner(y_rd)),
		.b      (der_rd),
		.done   (div_done),
		.res    (div_res),
		.sat    (div_sat)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			cv_q  <= '0;
			sat_q <= 1'b0;
			dup_q <= 1'b0;
			ov_q  <= 1'b0;
		end else begin
			if (emit) begin
				ov_q <= 1'b1;
			end else if (rsp_ready) begin
				ov_q <= 1'b0;
			end
			// sticky saturation, cleared at the start of a build or an evaluate
			if ((cmd.op == OP_BUILD_INIT) || (cmd.op == OP_EVAL_INIT)) begin
				sat_q <= 1'b0;
			end else begin
				sat_q <= sat_q | (mul_done & mul_sat) | (div_done & div_sat) |
					(is_add & add_r.sat);
			end
			case (cmd.op)
				OP_LOAD: begin
					if (cnt_q < CNT_W'(MAX_POINTS)) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				OP_CLEAR: cnt_q <= '0;
				OP_BUILD_INIT: begin
					cv_q  <= '0;
					dup_q <= 1'b0;
				end
				OP_DUPCMP: begin
					if (to_inner(x_rd) == xi_q) begin
						dup_q <= 1'b1;
					end
				end
				OP_EMIT_COEF: cv_q <= cnt_q;
				default: ;
			endcase
		end
	end

	// stores and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_in_q <= cmd_t'(req_command);
			inx_q    <= req_x;
			iny_q    <= req_y;
		end
		case (cmd.op)
			OP_LOAD: begin
				if (cnt_q < CNT_W'(MAX_POINTS)) begin
					xs_q[cnt_q[IDX_W-1:0]] <= inx_q;
					ys_q[cnt_q[IDX_W-1:0]] <= iny_q;
				end
			end
			OP_BUILD_INIT: begin
				for (int k = 0; k < MAX_POINTS; k++) begin
					coef_q[k] <= 64'sd0;
				end
				for (int k = 0; k <= MAX_POINTS; k++) begin
					poly_q[k] <= (k == 0) ? INNER_ONE : 64'sd0;
				end
			end
			OP_EVAL_INIT: begin
				xi_q  <= to_inner(inx_q);
				sum_q <= 64'sd0;
				pw_q  <= INNER_ONE;
			end
			OP_LATCH_XI: begin
				xi_q <= to_inner(x_rd);
				t_q  <= INNER_ONE;
			end
			OP_DIV:      xi_q <= to_inner(x_rd);
			OP_POLY_UPD: poly_q[cmd.idx] <= add_r.val;
			OP_POLY_WR0: poly_q[0] <= mul_res;
			OP_T_SET:    t_q <= mul_res;
			OP_DER_WR:   der_q[ix] <= t_q;
			OP_W_SET:    w_q <= div_res;
			OP_QUO_TOP:  quo_q[ix] <= poly_rd;
			OP_QUO_UPD:  quo_q[IDX_W'(ix - IDX_W'(1))] <= add_r.val;
			OP_COEF_UPD: coef_q[ix] <= add_r.val;
			OP_SUM_UPD:  sum_q <= add_r.val;
			OP_PW_UPD:   pw_q <= mul_res;
			OP_EMIT_COEF: begin
				o_val_q  <= coef_rd;
				o_idx_q  <= cmd.idx[3:0];
				o_coef_q <= 1'b1;
				o_last_q <= cmd.last;
				o_err_q  <= sat_q ? ERR_SAT : ERR_OK;
			end
			OP_EMIT_ERR: begin
				o_val_q  <= 64'sd0;
				o_idx_q  <= 4'd0;
				o_coef_q <= 1'b1;
				o_last_q <= 1'b1;
				o_err_q  <= dup_q ? ERR_DUP : ERR_OK;
			end
			OP_EMIT_EVAL: begin
				o_val_q  <= sum_q;
				o_idx_q  <= 4'd0;
				o_coef_q <= 1'b0;
				o_last_q <= 1'b1;
				o_err_q  <= sat_q ? ERR_SAT : ERR_OK;
			end
			default: ;
		endcase
	end

	// status to the sequencer
	always_comb begin
		stat.cmd      = cmd_in_q;
		stat.n        = cnt_q;
		stat.cv       = cv_q;
		stat.dup      = dup_q;
		stat.mul_done = mul_done;
		stat.div_done = div_done;
		stat.out_free = out_free;
		stat.in_valid = req_valid;
	end

	assign rsp_valid          = ov_q;
	assign rsp_result_value   = o_val_q;
	assign rsp_coef_index     = o_idx_q;
	assign rsp_is_coefficient = o_coef_q;
	assign rsp_last           = o_last_q;
	assign rsp_error          = o_err_q;

	// checks
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free) else $error("result register overwritten");
	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_busy) else $error("multiplier restarted while busy");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS)) else $error("point count overflow");
	a_units: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_done && div_done)) else $error("both units finished together");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !mul_busy) else $error("beat accepted while multiplier busy");

endmodule

@@ sv/lie_ctrl.sv @@
module lie_ctrl import lie_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d, n_m1;

	assign n_m1 = stat.n - CNT_W'(1);

	// state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
		end
	end

	// command dispatch and sequencing of the build and evaluate loops
	always_comb begin
		state_d      = state_q;
		i_d          = i_q;
		j_d          = j_q;
		k_d          = k_q;
		cmd.op       = OP_NONE;
		cmd.msel     = MS_NEGXI_POLY;
		cmd.idx      = '0;
		cmd.last     = 1'b0;
		cmd.in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				unique case (stat.cmd)
					CMD_LOAD: begin
						cmd.op  = OP_LOAD;
						state_d = ST_IDLE;
					end
					CMD_CLEAR: begin
						cmd.op  = OP_CLEAR;
						state_d = ST_IDLE;
					end
					CMD_EVAL: begin
						cmd.op  = OP_EVAL_INIT;
						k_d     = '0;
						state_d = ST_EV_CHK;
					end
					default: begin
						cmd.op  = OP_BUILD_INIT;
						i_d     = '0;
						state_d = (stat.n == '0) ? ST_EMIT_ERR : ST_DUP_XI;
					end
				endcase
			end
			// repeated node check
			ST_DUP_XI: begin
				if (i_q == n_m1) begin
					i_d     = '0;
					state_d = stat.dup ? ST_EMIT_ERR : ST_POLY_XI;
				end else begin
					cmd.op  = OP_LATCH_XI;
					cmd.idx = i_q;
					j_d     = i_q + CNT_W'(1);
					state_d = ST_DUP_CMP;
				end
			end
			ST_DUP_CMP: begin
				cmd.op  = OP_DUPCMP;
				cmd.idx = j_q;
				if (j_q == n_m1) begin
					i_d     = i_q + CNT_W'(1);
					state_d = ST_DUP_XI;
				end else begin
					j_d = j_q + CNT_W'(1);
				end
			end
			// node product polynomial
			ST_POLY_XI: begin
				cmd.op  = OP_LATCH_XI;
				cmd.idx = i_q;
				k_d     = i_q + CNT_W'(1);
				state_d = ST_POLY_MUL;
			end
			ST_POLY_MUL: begin
				cmd.op   = OP_MUL;
				cmd.msel = MS_NEGXI_POLY;
				cmd.idx  = k_q;
				state_d  = ST_POLY_WAIT;
			end
			ST_POLY_WAIT: begin
				if (stat.mul_done) begin
					if (k_q != '0) begin
						cmd.op  = OP_POLY_UPD;
						cmd.idx = k_q;
						k_d     = k_q - CNT_W'(1);
						state_d = ST_POLY_MUL;
					end else begin
						cmd.op = OP_POLY_WR0;
						if (i_q == n_m1) begin
							i_d     = '0;
							state_d = ST_DER_XI;
						end else begin
							i_d     = i_q + CNT_W'(1);
							state_d = ST_POLY_XI;
						end
					end
				end
			end
			// products of node differences
			ST_DER_XI: begin
				cmd.op  = OP_LATCH_XI;
				cmd.idx = i_q;
				j_d     = '0;
				state_d = ST_DER_MUL;
			end
			ST_DER_MUL: begin
				if (j_q == stat.n) begin
					cmd.op  = OP_DER_WR;
					cmd.idx = i_q;
					if (i_q == n_m1) begin
						i_d     = '0;
						state_d = ST_QUO_XI;
					end else begin
						i_d     = i_q + CNT_W'(1);
						state_d = ST_DER_XI;
					end
				end else if (j_q == i_q) begin
					j_d = j_q + CNT_W'(1);
				end else begin
					cmd.op   = OP_MUL;
					cmd.msel = MS_T_DIFF;
					cmd.idx  = j_q;
					state_d  = ST_DER_WAIT;
				end
			end
			ST_DER_WAIT: begin
				if (stat.mul_done) begin
					cmd.op  = OP_T_SET;
					j_d     = j_q + CNT_W'(1);
					state_d = ST_DER_MUL;
				end
			end
			// weight, synthetic division, accumulation
			ST_QUO_XI: begin
				cmd.op  = OP_DIV;
				cmd.idx = i_q;
				state_d = ST_QUO_DWAIT;
			end
			ST_QUO_DWAIT: begin
				if (stat.div_done) begin
					cmd.op  = OP_W_SET;
					state_d = ST_QUO_TOP;
				end
			end
			ST_QUO_TOP: begin
				cmd.op  = OP_QUO_TOP;
				cmd.idx = n_m1;
				k_d     = n_m1;
				state_d = ST_QUO_MUL;
			end
			ST_QUO_MUL: begin
				if (k_q == '0) begin
					state_d = ST_COEF_MUL;
				end else begin
					cmd.op   = OP_MUL;
					cmd.msel = MS_XI_QUO;
					cmd.idx  = k_q;
					state_d  = ST_QUO_WAIT;
				end
			end
			ST_QUO_WAIT: begin
				if (stat.mul_done) begin
					cmd.op  = OP_QUO_UPD;
					cmd.idx = k_q;
					k_d     = k_q - CNT_W'(1);
					state_d = ST_QUO_MUL;
				end
			end
			ST_COEF_MUL: begin
				cmd.op   = OP_MUL;
				cmd.msel = MS_QUO_W;
				cmd.idx  = k_q;
				state_d  = ST_COEF_WAIT;
			end
			ST_COEF_WAIT: begin
				if (stat.mul_done) begin
					cmd.op  = OP_COEF_UPD;
					cmd.idx = k_q;
					if (k_q == n_m1) begin
						k_d = '0;
						if (i_q == n_m1) begin
							state_d = ST_EMIT;
						end else begin
							i_d     = i_q + CNT_W'(1);
							state_d = ST_QUO_XI;
						end
					end else begin
						k_d     = k_q + CNT_W'(1);
						state_d = ST_COEF_MUL;
					end
				end
			end
			// coefficient beats
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.op   = OP_EMIT_COEF;
					cmd.idx  = k_q;
					cmd.last = (k_q == n_m1);
					if (k_q == n_m1) begin
						state_d = ST_IDLE;
					end else begin
						k_d = k_q + CNT_W'(1);
					end
				end
			end
			ST_EMIT_ERR: begin
				if (stat.out_free) begin
					cmd.op  = OP_EMIT_ERR;
					state_d = ST_IDLE;
				end
			end
			// power series evaluation
			ST_EV_CHK: begin
				if (k_q == stat.cv) begin
					state_d = ST_EV_EMIT;
				end else begin
					cmd.op   = OP_MUL;
					cmd.msel = MS_COEF_PW;
					cmd.idx  = k_q;
					state_d  = ST_EV_WAIT1;
				end
			end
			ST_EV_WAIT1: begin
				if (stat.mul_done) begin
					cmd.op = OP_SUM_UPD;
					if (k_q + CNT_W'(1) != stat.cv) begin
						state_d = ST_EV_MUL2;
					end else begin
						k_d     = k_q + CNT_W'(1);
						state_d = ST_EV_CHK;
					end
				end
			end
			ST_EV_MUL2: begin
				cmd.op   = OP_MUL;
				cmd.msel = MS_PW_XI;
				state_d  = ST_EV_WAIT2;
			end
			ST_EV_WAIT2: begin
				if (stat.mul_done) begin
					cmd.op  = OP_PW_UPD;
					k_d     = k_q + CNT_W'(1);
					state_d = ST_EV_CHK;
				end
			end
			ST_EV_EMIT: begin
				if (stat.out_free) begin
					cmd.op  = OP_EMIT_EVAL;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ sv/lagrange_interpolation_engine_unit.sv @@
// Lagrange interpolation engine.
// req channel: one beat per command (load point, build, evaluate, clear)
// with x_value and y_value in Q16.16. rsp channel: result beats in Q32.32.
// Load and clear give no result. Build with n points gives n coefficient
// beats, x^0 first, last set on the final one; with no points or a
// repeated x it gives one beat (error 1 for a repeated x). Evaluate gives
// one beat. Each product goes through one shared 32x32 multiplier over
// four partial products plus round and clamp; each weight comes from a
// one-bit-per-cycle divider. One command is worked at a time: req is ready
// only while the sequencer is idle, and the next command is accepted while
// the last result still waits in the output register.
// Reset clears the point count, the coefficient count and the output valid.
// A stalled rsp holds the result register and the sequencer waits for it.
module lagrange_interpolation_engine_unit import lie_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lie_req_if.sink   req,
	lie_rsp_if.source rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign req.ready = cmd.in_ready;

	lie_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	lie_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.req_valid          (req.valid),
		.req_command        (req.command),
		.req_x              (req.x_value),
		.req_y              (req.y_value),
		.rsp_ready          (rsp.ready),
		.rsp_valid          (rsp.valid),
		.rsp_result_value   (rsp.result_value),
		.rsp_coef_index     (rsp.coef_index),
		.rsp_is_coefficient (rsp.is_coefficient),
		.rsp_last           (rsp.last),
		.rsp_error          (rsp.error)
	);

endmodule

@@ dv/tb_lagrange_interpolation_engine_unit.sv @@
`timescale 1ns / 1ps

module tb_lagrange_interpolation_engine_unit;
	import lie_pkg::*;

	typedef struct {
		cmd_t        cmd;
		logic [31:0] x;
		logic [31:0] y;
		bit          drain;
	} command_beat_t;

	typedef struct {
		logic [63:0] value;
		logic [3:0]  idx;
		bit          coef;
		bit          last;
		err_t        err;
	} result_beat_t;

	logic clk;
	logic arst_n;

	lie_req_if req_ch();
	lie_rsp_if rsp_ch();

	lagrange_interpolation_engine_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	command_beat_t pending_cmds[$];
	result_beat_t  expected_results[$];
	int            mismatches;
	int            cmd_count;
	bit            req_fire;
	bit            offered;
	command_beat_t cur_beat;
	int            burst_left;
	int            gap_left;
	int            rsp_cycle;
	int            rsp_hold;

	// shadow state of the engine
	logic [31:0] node_x[MAX_POINTS];
	logic [31:0] node_y[MAX_POINTS];
	int          n_points;
	longint      coefs[MAX_POINTS];
	int          n_coefs;
	bit          sat_seen;

	// clock and reset
	always #10 clk = ~clk;

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.command = CMD_LOAD;
		req_ch.x_value = '0;
		req_ch.y_value = '0;
		rsp_ch.ready   = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// fixed point helpers
	function automatic longint point_to_q32(logic [31:0] raw);
		longint v;
		v = longint'($signed(raw));
		return v <<< FRAC_BITS;
	endfunction

	function automatic logic [63:0] magnitude(longint a);
		return a < 0 ? 64'(-a) : 64'(a);
	endfunction

	function automatic longint clamp_signed(logic [127:0] m, bit neg);
		logic [63:0] lim;
		lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		if (m[127:64] != 0 || m[63:0] > lim) begin
			sat_seen = 1'b1;
			m = {64'd0, lim};
		end
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	function automatic longint q_mul(longint a, longint b);
		logic [127:0] p;
		p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
		p = p + (128'd1 << (INNER_FRAC - 1));
		p = p >> INNER_FRAC;
		return clamp_signed(p, (a < 0) != (b < 0));
	endfunction

	function automatic longint q_add(longint a, longint b);
		longint s;
		s = a + b;
		if (a >= 0 && b >= 0 && s < 0) begin
			sat_seen = 1'b1;
			return INNER_MAX;
		end
		if (a < 0 && b < 0 && s >= 0) begin
			sat_seen = 1'b1;
			return INNER_MIN;
		end
		return s;
	endfunction

	function automatic longint q_div(longint a, longint b);
		logic [127:0] num, d, q, r;
		d = {64'd0, magnitude(b)};
		if (d == 0) begin
			if (a == 0)
				return 0;
			sat_seen = 1'b1;
			return a < 0 ? INNER_MIN : INNER_MAX;
		end
		num = {64'd0, magnitude(a)} << INNER_FRAC;
		q   = num / d;
		r   = num % d;
		if (r >= d - r)
			q = q + 1;
		return clamp_signed(q, (a < 0) != (b < 0));
	endfunction

	function automatic void push_result(longint v, int idx, bit coef, bit last, err_t e);
		result_beat_t rb;
		rb.value = v;
		rb.idx   = idx[3:0];
		rb.coef  = coef;
		rb.last  = last;
		rb.err   = e;
		expected_results.push_back(rb);
	endfunction

	// interpolating polynomial from the stored nodes
	function automatic void predict_build();
		longint node_poly[MAX_POINTS + 1];
		longint deriv[MAX_POINTS];
		longint quo[MAX_POINTS];
		longint negx, xi, p, w;
		int     n;
		n = n_points;
		for (int k = 0; k < MAX_POINTS; k++)
			coefs[k] = 0;
		n_coefs  = 0;
		sat_seen = 1'b0;
		if (n == 0) begin
			push_result(0, 0, 1, 1, ERR_OK);
			return;
		end
		for (int i = 0; i < n; i++)
			for (int j = i + 1; j < n; j++)
				if (node_x[i] == node_x[j]) begin
					push_result(0, 0, 1, 1, ERR_DUP);
					return;
				end
		// node product polynomial
		for (int k = 0; k <= MAX_POINTS; k++)
			node_poly[k] = 0;
		node_poly[0] = INNER_ONE;
		for (int i = 0; i < n; i++) begin
			negx = -point_to_q32(node_x[i]);
			for (int k = i + 1; k >= 1; k--)
				node_poly[k] = q_add(node_poly[k - 1], q_mul(negx, node_poly[k]));
			node_poly[0] = q_mul(negx, node_poly[0]);
		end
		// derivative at each node
		for (int i = 0; i < n; i++) begin
			xi = point_to_q32(node_x[i]);
			p  = INNER_ONE;
			for (int j = 0; j < n; j++)
				if (j != i)
					p = q_mul(p, xi - point_to_q32(node_x[j]));
			deriv[i] = p;
		end
		// weighted quotients accumulate into the coefficients
		for (int i = 0; i < n; i++) begin
			xi = point_to_q32(node_x[i]);
			w  = q_div(point_to_q32(node_y[i]), deriv[i]);
			quo[n - 1] = node_poly[n];
			for (int k = n - 1; k >= 1; k--)
				quo[k - 1] = q_add(node_poly[k], q_mul(xi, quo[k]));
			for (int k = 0; k < n; k++)
				coefs[k] = q_add(coefs[k], q_mul(quo[k], w));
		end
		n_coefs = n;
		for (int k = 0; k < n; k++)
			push_result(coefs[k], k, 1, k == n - 1, sat_seen ? ERR_SAT : ERR_OK);
	endfunction

	function automatic void predict_eval(logic [31:0] xraw);
		longint x, sum, pw;
		x        = point_to_q32(xraw);
		sum      = 0;
		pw       = INNER_ONE;
		sat_seen = 1'b0;
		for (int k = 0; k < n_coefs; k++) begin
			sum = q_add(sum, q_mul(coefs[k], pw));
			if (k + 1 < n_coefs)
				pw = q_mul(pw, x);
		end
		push_result(sum, 0, 0, 1, sat_seen ? ERR_SAT : ERR_OK);
	endfunction

	function automatic void predict_command(cmd_t c, logic [31:0] x, logic [31:0] y);
		case (c)
			CMD_LOAD: begin
				if (n_points < MAX_POINTS) begin
					node_x[n_points] = x;
					node_y[n_points] = y;
					n_points++;
				end
			end
			CMD_BUILD: predict_build();
			CMD_EVAL:  predict_eval(x);
			default:   n_points = 0;
		endcase
	endfunction

	task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// result checking and prediction at the rising edge
	always @(posedge clk) begin
		result_beat_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_results.size() == 0) begin
				flag_mismatch("unexpected beat", rsp_ch.result_value, 64'd0);
			end else begin
				want = expected_results.pop_front();
				if (rsp_ch.result_value !== want.value)
					flag_mismatch("result_value", rsp_ch.result_value, want.value);
				if (rsp_ch.coef_index !== want.idx)
					flag_mismatch("coef_index", rsp_ch.coef_index, want.idx);
				if (rsp_ch.is_coefficient !== want.coef)
					flag_mismatch("is_coefficient", rsp_ch.is_coefficient, want.coef);
				if (rsp_ch.last !== want.last)
					flag_mismatch("last", rsp_ch.last, want.last);
				if (rsp_ch.error !== want.err)
					flag_mismatch("error", rsp_ch.error, want.err);
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			predict_command(cmd_t'(req_ch.command), req_ch.x_value, req_ch.y_value);
			req_fire <= 1'b1;
		end else begin
			req_fire <= 1'b0;
		end
	end

	// command driver, bursts with random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_fire)
				offered = 1'b0;
			if (!offered) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cmds.size() > 0 &&
						!(pending_cmds[0].drain && expected_results.size() > 0)) begin
					cur_beat = pending_cmds.pop_front();
					offered  = 1'b1;
					if (burst_left == 0)
						burst_left = $urandom_range(1, 12);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
							: $urandom_range(0, 4);
				end
			end
			req_ch.valid   <= offered;
			req_ch.command <= cur_beat.cmd;
			req_ch.x_value <= cur_beat.x;
			req_ch.y_value <= cur_beat.y;
		end
	end

	// result receiver stall pattern, one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			rsp_cycle++;
			if (rsp_cycle >= 20000 && rsp_cycle < 24000) begin
				rsp_ch.ready <= 1'b0;
			end else if (rsp_hold > 0) begin
				rsp_hold--;
				rsp_ch.ready <= 1'b0;
			end else if (rsp_cycle % 2000 < 600) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				if ($urandom_range(0, 49) == 0)
					rsp_hold = $urandom_range(5, 40);
				rsp_ch.ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	task automatic queue_cmd(cmd_t c, logic [31:0] x, logic [31:0] y, bit drain = 1'b0);
		command_beat_t b;
		b.cmd   = c;
		b.x     = x;
		b.y     = y;
		b.drain = drain;
		pending_cmds.push_back(b);
		cmd_count++;
	endtask

	function automatic logic [31:0] small_q16();
		return 32'($signed($urandom_range(0, 2048)) - 1024) <<< 8;
	endfunction

	function automatic logic [31:0] any_word();
		return ($urandom_range(0, 1) == 0) ? small_q16() : $urandom;
	endfunction

	// one clear, load, build and evaluate sequence with random content
	task automatic queue_sequence();
		logic [31:0] xs[$];
		logic [31:0] xv;
		int          npts;
		int          nev;
		bit          unique_x;
		case ($urandom_range(0, 19))
			0:       npts = $urandom_range(16, 18);
			1, 2:    npts = $urandom_range(6, 15);
			default: npts = $urandom_range(1, 5);
		endcase
		queue_cmd(CMD_CLEAR, $urandom, $urandom);
		for (int i = 0; i < npts; i++) begin
			do begin
				xv = ($urandom_range(0, 4) == 0) ? $urandom : small_q16();
				unique_x = 1'b1;
				foreach (xs[j])
					if (xs[j] == xv)
						unique_x = 1'b0;
			end while (!unique_x);
			if (i > 0 && $urandom_range(0, 29) == 0)
				xv = xs[$urandom_range(0, i - 1)];
			xs.push_back(xv);
			queue_cmd(CMD_LOAD, xv, any_word());
		end
		queue_cmd(CMD_BUILD, $urandom, $urandom);
		nev = $urandom_range(1, 3);
		for (int i = 0; i < nev; i++)
			queue_cmd(CMD_EVAL, ($urandom_range(0, 2) == 0) ? $urandom : small_q16(),
				$urandom, ($urandom_range(0, 24) == 0));
	endtask

	// stimulus and end of run
	initial begin
		offered    = 1'b0;
		burst_left = 0;
		gap_left   = 0;
		rsp_cycle  = 0;
		rsp_hold   = 0;
		mismatches = 0;
		cmd_count  = 0;
		n_points   = 0;
		n_coefs    = 0;
		for (int k = 0; k < MAX_POINTS; k++)
			coefs[k] = 0;

		// evaluate with nothing built, build with no points
		queue_cmd(CMD_EVAL, 32'h7fff_ffff, 32'h8000_0000);
		queue_cmd(CMD_BUILD, 32'h0, 32'h0);
		// extreme nodes, saturating build
		queue_cmd(CMD_LOAD, 32'h7fff_ffff, 32'h8000_0000);
		queue_cmd(CMD_LOAD, 32'h8000_0000, 32'h7fff_ffff);
		queue_cmd(CMD_BUILD, 32'hffff_ffff, 32'hffff_ffff);
		queue_cmd(CMD_EVAL, 32'h7fff_ffff, 32'h0);
		queue_cmd(CMD_EVAL, 32'h8000_0000, 32'h0);
		// repeated node x clears the coefficients
		queue_cmd(CMD_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
		queue_cmd(CMD_LOAD, 32'h0, 32'h0001_0000);
		queue_cmd(CMD_LOAD, 32'h0, 32'h0002_0000);
		queue_cmd(CMD_BUILD, 32'h0, 32'h0);
		queue_cmd(CMD_EVAL, 32'h0001_0000, 32'h0);
		// nodes one lsb apart, derivative rounds to zero
		queue_cmd(CMD_CLEAR, 32'h0, 32'h0);
		for (int i = 0; i < 4; i++)
			queue_cmd(CMD_LOAD, i, (i == 1) ? 32'h0 : 32'hfff0_0000 + i);
		queue_cmd(CMD_BUILD, 32'h0, 32'h0);
		// ordinary small polynomial
		queue_cmd(CMD_CLEAR, 32'h0, 32'h0, 1'b1);
		queue_cmd(CMD_LOAD, 32'h0001_0000, 32'h0002_0000);
		queue_cmd(CMD_LOAD, 32'h0002_0000, 32'hffff_0000);
		queue_cmd(CMD_LOAD, 32'hfffe_8000, 32'h0000_8000);
		queue_cmd(CMD_BUILD, 32'h0, 32'h0);
		queue_cmd(CMD_EVAL, 32'h0000_8000, 32'h0);
		queue_cmd(CMD_EVAL, 32'hfffe_0000, 32'h0);

		// random part: mostly well-formed sequences, some noise
		while (cmd_count < 500) begin
			if ($urandom_range(0, 4) != 0) begin
				queue_sequence();
			end else begin
				repeat ($urandom_range(1, 4))
					queue_cmd(cmd_t'($urandom_range(0, 3)), $urandom, $urandom);
			end
		end

		wait (pending_cmds.size() == 0 && !offered);
		wait (expected_results.size() == 0);
		repeat (500) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#100_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/lie_pkg.sv
sv/lie_req_if.sv
sv/lie_rsp_if.sv
sv/lie_mul.sv
sv/lie_div.sv
sv/lie_dp.sv
sv/lie_ctrl.sv
sv/lagrange_interpolation_engine_unit.sv
dv/tb_lagrange_interpolation_engine_unit.sv
